### sv/ecgar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgar_pkg
// Shared types, constants and arithmetic helpers of the ECG auto-range axis
// tracker.
// ----------------------------------------------------------------------------
package ecgar_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int AXIS_W       = 32;
    localparam int CALCNT_W     = 10;
    localparam int PERIOD_W     = 24;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 1;
    localparam int TIMER_BITS_D = 24;
    localparam int WIDE_W       = 40;

    localparam logic [CALCNT_W-1:0] CAL_SAMPLES_RST = CALCNT_W'(300);
    localparam logic [PERIOD_W-1:0] AUTO_PERIOD_RST = PERIOD_W'(10000);

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // ceil(2^34 / 5): x/5 = (x * R) >> 34, x/10 = (x * R) >> 35 for any 32-bit x
    localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;

    localparam logic [CFG_INDEX_W-1:0] CFG_CAL_SAMPLES = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_ZOOM   = 2'd2,
        OP_PAN    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                         op;
        logic signed [SAMPLE_W-1:0]  sample;
        logic                        direction;
    } in_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] shown_min;
        logic signed [AXIS_W-1:0] shown_max;
        logic                     calibrated;
        logic                     range_updated;
    } res_t;

    function automatic logic signed [AXIS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'({1'b0, {(AXIS_W-1){1'b1}}});
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return hi[AXIS_W-1:0];
        end else if (v < lo) begin
            return lo[AXIS_W-1:0];
        end
        return v[AXIS_W-1:0];
    endfunction

    // halve, truncating toward zero
    function automatic logic signed [WIDE_W-1:0] half_trunc(input logic signed [WIDE_W-1:0] t);
        logic signed [WIDE_W-1:0] u;
        u = t + WIDE_W'(t[WIDE_W-1]);
        return u >>> 1;
    endfunction

endpackage

### sv/ecgar_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgar_core
// Tracker state, configuration registers and the combinational update that
// turns one accepted transaction into the next state and its result.
// ----------------------------------------------------------------------------
module ecgar_core #(
    parameter int TIMER_BITS = ecgar_pkg::TIMER_BITS_D
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ecgar_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ecgar_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                in_accept,
    input  ecgar_pkg::in_t                      in_data,
    output ecgar_pkg::res_t                     res
);

    localparam int SW = ecgar_pkg::SAMPLE_W;
    localparam int AW = ecgar_pkg::AXIS_W;
    localparam int WW = ecgar_pkg::WIDE_W;

    logic [ecgar_pkg::CALCNT_W-1:0] cal_samples_reg;
    logic [ecgar_pkg::PERIOD_W-1:0] auto_period_reg;

    logic                           locked_reg, locked_next;
    logic [ecgar_pkg::CALCNT_W-1:0] cal_count_reg, cal_count_next;
    logic signed [SW-1:0]           cal_low_reg, cal_low_next;
    logic signed [SW-1:0]           cal_high_reg, cal_high_next;
    logic signed [SW-1:0]           window_low_reg, window_low_next;
    logic signed [SW-1:0]           window_high_reg, window_high_next;
    logic signed [AW-1:0]           axis_low_reg, axis_low_next;
    logic signed [AW-1:0]           axis_high_reg, axis_high_next;
    logic signed [AW-1:0]           shown_low_reg, shown_low_next;
    logic signed [AW-1:0]           shown_high_reg, shown_high_next;
    logic [TIMER_BITS-1:0]          elapsed_reg, elapsed_next;
    logic                           first_window_done_reg, first_window_done_next;
    logic                           updated;

    logic signed [SW-1:0]           s;
    logic signed [SW-1:0]           win_low_upd, win_high_upd;
    logic signed [SW-1:0]           cal_low_upd, cal_high_upd;
    logic [ecgar_pkg::CALCNT_W-1:0] cal_count_inc;
    logic                           lock_now;
    logic                           roll_due;
    logic signed [SW:0]             cal_diff;
    logic [31:0]                    cal_range;
    logic signed [AW:0]             axis_range;
    logic [AW-2:0]                  amp;
    logic [31:0]                    mul_a;
    logic [63:0]                    mul_p;
    logic [29:0]                    pad;
    logic [28:0]                    pan_step;
    logic signed [AW-1:0]           lock_low, lock_high;
    logic signed [WW-1:0]           center, k_amp, zoom_hi_t, zoom_lo_t;
    logic signed [AW-1:0]           zoom_low, zoom_high;
    logic signed [AW-1:0]           pan_low, pan_high;

    assign s = in_data.sample;

    assign win_low_upd   = (s < window_low_reg)  ? s : window_low_reg;
    assign win_high_upd  = (s > window_high_reg) ? s : window_high_reg;
    assign cal_low_upd   = (s < cal_low_reg)     ? s : cal_low_reg;
    assign cal_high_upd  = (s > cal_high_reg)    ? s : cal_high_reg;
    assign cal_count_inc = (cal_count_reg != '1) ? cal_count_reg + 1'b1 : cal_count_reg;
    assign lock_now      = (cal_count_inc >= cal_samples_reg);
    assign roll_due      = (32'(elapsed_reg) > 32'(auto_period_reg));

    // spans never go negative: high >= low holds for both calibration and axis
    assign cal_diff   = (SW+1)'(cal_high_upd) - (SW+1)'(cal_low_upd);
    assign cal_range  = 32'($unsigned(cal_diff));
    assign axis_range = (AW+1)'(axis_high_reg) - (AW+1)'(axis_low_reg);
    assign amp        = axis_range[AW-1:1];

    // one shared reciprocal multiplier: range/20 at lock, range/10 for pan
    assign mul_a    = (in_data.op == ecgar_pkg::OP_PAN) ? axis_range[AW-1:0]
                                                        : {2'b00, cal_range[31:2]};
    assign mul_p    = {32'd0, mul_a} * {32'd0, ecgar_pkg::DIV5_RECIP};
    assign pad      = mul_p[63:34];
    assign pan_step = mul_p[63:35];

    assign lock_low  = ecgar_pkg::sat32(WW'(cal_low_upd) - WW'(pad));
    assign lock_high = ecgar_pkg::sat32(WW'(cal_high_upd) + WW'(pad));

    assign center    = WW'(axis_low_reg) + WW'(amp);
    assign k_amp     = in_data.direction ? WW'(amp) + (WW'(amp) <<< 1) : WW'(amp);
    assign zoom_hi_t = (center <<< 1) + k_amp;
    assign zoom_lo_t = (center <<< 1) - k_amp;
    assign zoom_high = ecgar_pkg::sat32(ecgar_pkg::half_trunc(zoom_hi_t));
    assign zoom_low  = ecgar_pkg::sat32(ecgar_pkg::half_trunc(zoom_lo_t));

    assign pan_high = in_data.direction ? ecgar_pkg::sat32(WW'(axis_high_reg) + WW'(pan_step))
                                        : ecgar_pkg::sat32(WW'(axis_high_reg) - WW'(pan_step));
    assign pan_low  = in_data.direction ? ecgar_pkg::sat32(WW'(axis_low_reg) + WW'(pan_step))
                                        : ecgar_pkg::sat32(WW'(axis_low_reg) - WW'(pan_step));

    always_comb begin
        locked_next            = locked_reg;
        cal_count_next         = cal_count_reg;
        cal_low_next           = cal_low_reg;
        cal_high_next          = cal_high_reg;
        window_low_next        = window_low_reg;
        window_high_next       = window_high_reg;
        axis_low_next          = axis_low_reg;
        axis_high_next         = axis_high_reg;
        shown_low_next         = shown_low_reg;
        shown_high_next        = shown_high_reg;
        elapsed_next           = elapsed_reg;
        first_window_done_next = first_window_done_reg;
        updated                = 1'b0;
        if (in_accept) begin
            unique case (in_data.op)
                ecgar_pkg::OP_SAMPLE: begin
                    window_low_next  = win_low_upd;
                    window_high_next = win_high_upd;
                    if (!locked_reg) begin
                        cal_low_next   = cal_low_upd;
                        cal_high_next  = cal_high_upd;
                        cal_count_next = cal_count_inc;
                        if (lock_now) begin
                            axis_low_next   = lock_low;
                            axis_high_next  = lock_high;
                            shown_low_next  = lock_low;
                            shown_high_next = lock_high;
                            locked_next     = 1'b1;
                            elapsed_next    = '0;
                            updated         = 1'b1;
                        end
                    end else if (roll_due) begin
                        if (first_window_done_reg) begin
                            shown_low_next  = AW'(win_low_upd);
                            shown_high_next = AW'(win_high_upd);
                            updated         = 1'b1;
                        end
                        window_low_next        = s;
                        window_high_next       = s;
                        elapsed_next           = '0;
                        first_window_done_next = 1'b1;
                    end
                end
                ecgar_pkg::OP_TICK: begin
                    if (elapsed_reg != '1) begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                end
                ecgar_pkg::OP_ZOOM: begin
                    if (amp != '0) begin
                        axis_low_next   = zoom_low;
                        axis_high_next  = zoom_high;
                        shown_low_next  = zoom_low;
                        shown_high_next = zoom_high;
                        updated         = 1'b1;
                    end
                end
                ecgar_pkg::OP_PAN: begin
                    if (axis_range != '0) begin
                        axis_low_next   = pan_low;
                        axis_high_next  = pan_high;
                        shown_low_next  = pan_low;
                        shown_high_next = pan_high;
                        updated         = 1'b1;
                    end
                end
            endcase
        end
    end

    assign res.shown_min     = shown_low_next;
    assign res.shown_max     = shown_high_next;
    assign res.calibrated    = locked_next;
    assign res.range_updated = updated;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_samples_reg <= ecgar_pkg::CAL_SAMPLES_RST;
            auto_period_reg <= ecgar_pkg::AUTO_PERIOD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ecgar_pkg::CFG_CAL_SAMPLES: cal_samples_reg <= cfg_wdata[ecgar_pkg::CALCNT_W-1:0];
                ecgar_pkg::CFG_AUTO_PERIOD: auto_period_reg <= cfg_wdata[ecgar_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            locked_reg            <= 1'b0;
            cal_count_reg         <= '0;
            cal_low_reg           <= ecgar_pkg::SMP_MAX;
            cal_high_reg          <= ecgar_pkg::SMP_MIN;
            window_low_reg        <= ecgar_pkg::SMP_MAX;
            window_high_reg       <= ecgar_pkg::SMP_MIN;
            axis_low_reg          <= '0;
            axis_high_reg         <= '0;
            shown_low_reg         <= '0;
            shown_high_reg        <= '0;
            elapsed_reg           <= '0;
            first_window_done_reg <= 1'b0;
        end else begin
            locked_reg            <= locked_next;
            cal_count_reg         <= cal_count_next;
            cal_low_reg           <= cal_low_next;
            cal_high_reg          <= cal_high_next;
            window_low_reg        <= window_low_next;
            window_high_reg       <= window_high_next;
            axis_low_reg          <= axis_low_next;
            axis_high_reg         <= axis_high_next;
            shown_low_reg         <= shown_low_next;
            shown_high_reg        <= shown_high_next;
            elapsed_reg           <= elapsed_next;
            first_window_done_reg <= first_window_done_next;
        end
    end

    a_lock_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        locked_reg |=> locked_reg)
        else $error("lock dropped");

    a_axis_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        axis_high_reg >= axis_low_reg)
        else $error("axis bounds inverted");

    a_lock_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(locked_reg) |-> (elapsed_reg == '0))
        else $error("elapsed ticks not cleared at lock");

    a_tick_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_data.op == ecgar_pkg::OP_TICK) |-> !res.range_updated)
        else $error("timer tick reported a range update");

    a_window_only_after_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        first_window_done_reg |-> locked_reg)
        else $error("window restarted before lock");

endmodule

### sv/ecgar_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgar_skid
// Two-entry output buffer: a result register plus a skid register, so the
// input side keeps taking transactions while one result waits downstream.
// ----------------------------------------------------------------------------
module ecgar_skid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ecgar_pkg::res_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ecgar_pkg::res_t out_data
);

    logic            out_valid_reg, out_valid_next;
    ecgar_pkg::res_t out_data_reg, out_data_next;
    logic            skid_valid_reg, skid_valid_next;
    ecgar_pkg::res_t skid_data_reg, skid_data_next;
    logic            take;

    assign in_ready = !skid_valid_reg;
    assign take     = in_valid && in_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = take;
                out_data_next  = in_data;
            end
        end else if (take) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### sv/ecg_auto_range_axis_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg_auto_range_axis_tracker
// Auto-ranging display axis for a signed ECG sample stream: calibration,
// rolling window min/max, zoom and pan, one result per transaction.
// ----------------------------------------------------------------------------
// Each result is registered in the output buffer before it is valid on m_data.
// Throughput: one transaction per cycle while s_ready is high; the state update is
//   combinational, with one shared 32x32 reciprocal multiplier (pad at lock, pan step).
// The two-entry output buffer keeps s_ready high while one result is stalled.
// Reset (aresetn low, synchronous): axis unlocked, bounds and counters zero,
//   min/max trackers at their extremes, cal_samples 300, auto_period 10000.
// ----------------------------------------------------------------------------
module ecg_auto_range_axis_tracker #(
    parameter int TIMER_BITS = ecgar_pkg::TIMER_BITS_D
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ecgar_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ecgar_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ecgar_pkg::in_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ecgar_pkg::res_t                   m_data
);

    ecgar_pkg::res_t res;
    logic            accept;

    assign accept = s_valid && s_ready;

    ecgar_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (accept),
        .in_data   (s_data),
        .res       (res)
    );

    ecgar_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
